@@ design/dgm_pkg.sv @@
// shared types, constants and byte tables for the drum grid midi track encoder
package dgm_pkg;

  // tick counts stay below 2^14 at the default parameter values
  localparam int TICK_W = 14;
  localparam int GENE_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH = 4;

  // default parameter values
  localparam int DEF_NUM_STEPS = 16;
  localparam int DEF_TICKS_PER_QUARTER = 480;

  // q1.16 arithmetic
  localparam logic [GENE_W-1:0] Q16_ONE = 17'h10000;
  localparam logic [23:0] Q16_HALF = 24'h008000;
  localparam logic [23:0] VEL_SPAN = 24'd87;
  localparam logic [6:0] VEL_BASE = 7'd40;

  // midi codes
  localparam logic [7:0] STATUS_NOTE_ON = 8'h99;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h89;
  localparam logic [6:0] RELEASE_VEL = 7'h40;
  localparam logic [TICK_W-1:0] VLQ_ONE_BYTE_MAX = 14'd127;

  // byte positions of the last byte of each command and of the note command fields
  localparam logic [2:0] TEMPO_LAST_IDX = 3'd6;
  localparam logic [2:0] EOT_LAST_IDX = 3'd3;
  localparam logic [2:0] NOTE_LAST_IDX = 3'd4;
  localparam logic [2:0] NOTE_IDX_DELTA_HI = 3'd0;
  localparam logic [2:0] NOTE_IDX_DELTA_LO = 3'd1;
  localparam logic [2:0] NOTE_IDX_STATUS = 3'd2;
  localparam logic [2:0] NOTE_IDX_NOTE = 3'd3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KICK_DENSITY = 3'd0,
    REG_KICK_VEL_GENE = 3'd1,
    REG_SNARE_DENSITY = 3'd2,
    REG_SNARE_VEL_GENE = 3'd3,
    REG_CHAT_DENSITY = 3'd4,
    REG_CHAT_VEL_GENE = 3'd5,
    REG_OHAT_DENSITY = 3'd6,
    REG_OHAT_VEL_GENE = 3'd7
  } cfg_reg_t;

  // command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_TEMPO = 2'd0,
    CMD_NOTE_ON = 2'd1,
    CMD_NOTE_OFF = 2'd2,
    CMD_EOT = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [TICK_W-1:0] delta;
    logic [7:0] note;
    logic [6:0] vel;
    logic last;
  } cmd_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // front sequencer states
  typedef enum logic [2:0] {
    FR_IDLE,
    FR_HEAD,
    FR_HITS,
    FR_LO,
    FR_SCAN,
    FR_TAIL,
    FR_FLUSH
  } fr_state_t;

  // voice note numbers: kick, snare, closed hat, open hat
  function automatic logic [7:0] voice_note(input logic [1:0] v);
    logic [7:0] n;
    case (v)
      2'd0: n = 8'd36;
      2'd1: n = 8'd38;
      2'd2: n = 8'd42;
      2'd3: n = 8'd46;
      default: n = 8'd36;
    endcase
    return n;
  endfunction

  // tempo meta event with zero delta
  function automatic logic [7:0] tempo_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h00;
      3'd1: b = 8'hFF;
      3'd2: b = 8'h51;
      3'd3: b = 8'h03;
      3'd4: b = 8'h07;
      3'd5: b = 8'hA1;
      3'd6: b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // end-of-track meta event with zero delta
  function automatic logic [7:0] eot_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h00;
      3'd1: b = 8'hFF;
      3'd2: b = 8'h2F;
      3'd3: b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ design/dgm_queue.sv @@
// small command queue between the slot front end and the byte serializer
module dgm_queue #(
  parameter int DEPTH = dgm_pkg::Q_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dgm_pkg::cmd_t  din,
  input  logic           pop,
  output dgm_pkg::cmd_t  dout,
  output dgm_pkg::q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dgm_pkg::cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign stat.full = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign dout = mem_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop = pop && !stat.empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ design/dgm_front.sv @@
// slot front end: config registers, bar position, hit search, command issue
module dgm_front #(
  parameter int NUM_STEPS = dgm_pkg::DEF_NUM_STEPS,
  parameter int TICKS_PER_QUARTER = dgm_pkg::DEF_TICKS_PER_QUARTER
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dgm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dgm_pkg::GENE_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_restart_bar,
  input  dgm_pkg::q_stat_t                q_stat,
  output logic                            q_push,
  output dgm_pkg::cmd_t                   q_din
);

  localparam int STEP = TICKS_PER_QUARTER / 4;
  localparam int GATE = STEP / 2;
  localparam int END_T = NUM_STEPS * STEP;
  localparam int SW = $clog2(NUM_STEPS + 1);
  localparam int TMW = $clog2(STEP + 1);
  localparam int PW = $clog2(NUM_STEPS * NUM_STEPS + 1);
  localparam int TW = dgm_pkg::TICK_W;
  localparam int GW = dgm_pkg::GENE_W;

  // config registers, one array per gene kind
  logic [GW-1:0] dens_r [4];
  logic [GW-1:0] velg_r [4];

  dgm_pkg::fr_state_t state_r, state_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic [TMW-1:0] tm_r, tm_nxt;
  logic [SW-1:0] sidx_r, sidx_nxt;
  logic [TW-1:0] last_r, last_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [1:0] voice_r, voice_nxt;
  logic [SW-1:0] hits_r, hits_nxt;
  logic [PW-1:0] lo_r, lo_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic [SW-1:0] j_r, j_nxt;
  logic [6:0] vel_r, vel_nxt;
  dgm_pkg::cmd_t pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;

  logic [GW-1:0] dens_cl, velg_cl;
  logic [23:0] hit_prod, hit_sum, vel_prod;
  logic [SW-1:0] hits_raw;
  logic [2*SW-1:0] lo_prod;
  logic [PW:0] hi_bound;
  logic [TW:0] t_plus;
  logic [TMW:0] tm_sum;
  logic onbeat, at_end, can_load, load_req, flush_req;
  logic [SW-1:0] step_c;
  dgm_pkg::cmd_t load_cmd;

  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == dgm_pkg::FR_IDLE);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        dens_r[i] <= '0;
        velg_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (dgm_pkg::cfg_reg_t'(cfg_index))
        dgm_pkg::REG_KICK_DENSITY:   dens_r[0] <= cfg_data;
        dgm_pkg::REG_KICK_VEL_GENE:  velg_r[0] <= cfg_data;
        dgm_pkg::REG_SNARE_DENSITY:  dens_r[1] <= cfg_data;
        dgm_pkg::REG_SNARE_VEL_GENE: velg_r[1] <= cfg_data;
        dgm_pkg::REG_CHAT_DENSITY:   dens_r[2] <= cfg_data;
        dgm_pkg::REG_CHAT_VEL_GENE:  velg_r[2] <= cfg_data;
        dgm_pkg::REG_OHAT_DENSITY:   dens_r[3] <= cfg_data;
        dgm_pkg::REG_OHAT_VEL_GENE:  velg_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-voice hit count and velocity arithmetic
  always_comb begin
    dens_cl = (dens_r[voice_r] > dgm_pkg::Q16_ONE) ? dgm_pkg::Q16_ONE : dens_r[voice_r];
    velg_cl = (velg_r[voice_r] > dgm_pkg::Q16_ONE) ? dgm_pkg::Q16_ONE : velg_r[voice_r];
    hit_prod = 24'(dens_cl) * 24'(NUM_STEPS);
    hit_sum = hit_prod + dgm_pkg::Q16_HALF;
    hits_raw = hit_sum[16 +: SW];
    vel_prod = 24'(velg_cl) * dgm_pkg::VEL_SPAN;
    lo_prod = step_r * hits_r;
    hi_bound = {1'b0, lo_r} + (PW+1)'(hits_r);
  end

  // slot position within the bar
  always_comb begin
    t_plus = (TW+1)'(t_r) + (TW+1)'(GATE);
    at_end = t_plus > (TW+1)'(END_T);
    tm_sum = (TMW+1)'(tm_r) + (TMW+1)'(GATE);
    onbeat = (tm_r == '0);
    step_c = (onbeat || tm_r >= TMW'(GATE)) ? sidx_r : sidx_r - SW'(1);
  end

  assign can_load = !pend_v_r || !q_stat.full;

  // sequencer: next state, datapath and command issue
  always_comb begin
    state_nxt = state_r;
    t_nxt = t_r;
    tm_nxt = tm_r;
    sidx_nxt = sidx_r;
    last_nxt = last_r;
    step_nxt = step_r;
    voice_nxt = voice_r;
    hits_nxt = hits_r;
    lo_nxt = lo_r;
    acc_nxt = acc_r;
    j_nxt = j_r;
    vel_nxt = vel_r;
    pend_nxt = pend_r;
    pend_v_nxt = pend_v_r;
    load_req = 1'b0;
    flush_req = 1'b0;
    load_cmd.kind = dgm_pkg::CMD_TEMPO;
    load_cmd.delta = '0;
    load_cmd.note = '0;
    load_cmd.vel = '0;
    load_cmd.last = 1'b0;

    case (state_r)
      dgm_pkg::FR_IDLE: begin
        if (in_valid) begin
          if (in_restart_bar) begin
            t_nxt = '0;
            tm_nxt = '0;
            sidx_nxt = '0;
            last_nxt = '0;
          end
          state_nxt = dgm_pkg::FR_HEAD;
        end
      end
      dgm_pkg::FR_HEAD: begin
        // tempo meta leads the bar
        if (t_r == '0) begin
          load_req = 1'b1;
          load_cmd.kind = dgm_pkg::CMD_TEMPO;
        end
        if (t_r != '0 || can_load) begin
          step_nxt = step_c;
          voice_nxt = '0;
          state_nxt = (step_c < SW'(NUM_STEPS)) ? dgm_pkg::FR_HITS : dgm_pkg::FR_TAIL;
        end
      end
      dgm_pkg::FR_HITS: begin
        // kick and snare never drop below one hit
        if (voice_r < 2'd2 && hits_raw == '0) begin
          hits_nxt = SW'(1);
        end else begin
          hits_nxt = hits_raw;
        end
        vel_nxt = dgm_pkg::VEL_BASE + vel_prod[22:16];
        state_nxt = dgm_pkg::FR_LO;
      end
      dgm_pkg::FR_LO: begin
        lo_nxt = PW'(lo_prod);
        acc_nxt = '0;
        j_nxt = '0;
        state_nxt = dgm_pkg::FR_SCAN;
      end
      dgm_pkg::FR_SCAN: begin
        // walk j*NUM_STEPS up to the window [step*hits, (step+1)*hits)
        if (j_r == hits_r || (acc_r >= lo_r && {1'b0, acc_r} >= hi_bound)) begin
          voice_nxt = voice_r + 2'd1;
          state_nxt = (voice_r == 2'd3) ? dgm_pkg::FR_TAIL : dgm_pkg::FR_HITS;
        end else if (acc_r >= lo_r) begin
          load_req = 1'b1;
          load_cmd.kind = onbeat ? dgm_pkg::CMD_NOTE_ON : dgm_pkg::CMD_NOTE_OFF;
          load_cmd.delta = t_r - last_r;
          load_cmd.note = dgm_pkg::voice_note(voice_r);
          load_cmd.vel = onbeat ? vel_r : dgm_pkg::RELEASE_VEL;
          if (can_load) begin
            last_nxt = t_r;
            voice_nxt = voice_r + 2'd1;
            state_nxt = (voice_r == 2'd3) ? dgm_pkg::FR_TAIL : dgm_pkg::FR_HITS;
          end
        end else begin
          acc_nxt = acc_r + PW'(NUM_STEPS);
          j_nxt = j_r + SW'(1);
        end
      end
      dgm_pkg::FR_TAIL: begin
        if (at_end) begin
          load_req = 1'b1;
          load_cmd.kind = dgm_pkg::CMD_EOT;
          if (can_load) begin
            state_nxt = dgm_pkg::FR_FLUSH;
          end
        end else begin
          state_nxt = dgm_pkg::FR_FLUSH;
        end
      end
      dgm_pkg::FR_FLUSH: begin
        // last command of the slot goes out marked, then the bar advances
        flush_req = 1'b1;
        if (!pend_v_r || !q_stat.full) begin
          pend_v_nxt = 1'b0;
          if (at_end) begin
            t_nxt = '0;
            tm_nxt = '0;
            sidx_nxt = '0;
            last_nxt = '0;
          end else begin
            t_nxt = t_plus[TW-1:0];
            if (tm_sum >= (TMW+1)'(STEP)) begin
              tm_nxt = TMW'(tm_sum - (TMW+1)'(STEP));
              sidx_nxt = sidx_r + SW'(1);
            end else begin
              tm_nxt = tm_sum[TMW-1:0];
            end
          end
          state_nxt = dgm_pkg::FR_IDLE;
        end
      end
      default: state_nxt = dgm_pkg::FR_IDLE;
    endcase

    // one-deep holding slot so the final command can carry the slot end mark
    if (load_req && can_load) begin
      pend_nxt = load_cmd;
      pend_v_nxt = 1'b1;
    end
  end

  assign q_push = pend_v_r && !q_stat.full && ((load_req && can_load) || flush_req);

  always_comb begin
    q_din = pend_r;
    q_din.last = flush_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dgm_pkg::FR_IDLE;
      t_r <= '0;
      tm_r <= '0;
      sidx_r <= '0;
      last_r <= '0;
      pend_v_r <= 1'b0;
      voice_r <= '0;
    end else begin
      state_r <= state_nxt;
      t_r <= t_nxt;
      tm_r <= tm_nxt;
      sidx_r <= sidx_nxt;
      last_r <= last_nxt;
      pend_v_r <= pend_v_nxt;
      voice_r <= voice_nxt;
    end
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    hits_r <= hits_nxt;
    lo_r <= lo_nxt;
    acc_r <= acc_nxt;
    j_r <= j_nxt;
    vel_r <= vel_nxt;
    pend_r <= pend_nxt;
  end

endmodule

@@ design/dgm_back.sv @@
// byte serializer: turns queued commands into track bytes, one per beat
module dgm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dgm_pkg::cmd_t        q_dout,
  input  dgm_pkg::q_stat_t     q_stat,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_track_byte,
  output logic                 out_bar_done,
  output logic                 out_last_of_slot
);

  dgm_pkg::cmd_t cmd_r, cmd_nxt;
  logic cmd_v_r, cmd_v_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic out_v_r, out_v_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic bar_r, bar_nxt;
  logic los_r, los_nxt;
  logic [7:0] cur_byte;
  logic cur_final, emit;

  assign out_valid = out_v_r;
  assign out_track_byte = byte_r;
  assign out_bar_done = bar_r;
  assign out_last_of_slot = los_r;

  assign q_pop = !cmd_v_r && !q_stat.empty;
  assign emit = cmd_v_r && (!out_v_r || out_ready);

  // byte at the current position of the command
  always_comb begin
    cur_byte = '0;
    cur_final = 1'b0;
    case (cmd_r.kind)
      dgm_pkg::CMD_TEMPO: begin
        cur_byte = dgm_pkg::tempo_byte(idx_r);
        cur_final = (idx_r == dgm_pkg::TEMPO_LAST_IDX);
      end
      dgm_pkg::CMD_EOT: begin
        cur_byte = dgm_pkg::eot_byte(idx_r);
        cur_final = (idx_r == dgm_pkg::EOT_LAST_IDX);
      end
      default: begin
        case (idx_r)
          dgm_pkg::NOTE_IDX_DELTA_HI: cur_byte = {1'b1, cmd_r.delta[13:7]};
          dgm_pkg::NOTE_IDX_DELTA_LO: cur_byte = {1'b0, cmd_r.delta[6:0]};
          dgm_pkg::NOTE_IDX_STATUS:
            cur_byte = (cmd_r.kind == dgm_pkg::CMD_NOTE_ON) ?
                       dgm_pkg::STATUS_NOTE_ON : dgm_pkg::STATUS_NOTE_OFF;
          dgm_pkg::NOTE_IDX_NOTE: cur_byte = cmd_r.note;
          default: cur_byte = {1'b0, cmd_r.vel};
        endcase
        cur_final = (idx_r == dgm_pkg::NOTE_LAST_IDX);
      end
    endcase
  end

  // command fetch, byte walk and output register
  always_comb begin
    cmd_nxt = cmd_r;
    cmd_v_nxt = cmd_v_r;
    idx_nxt = idx_r;
    out_v_nxt = out_v_r;
    byte_nxt = byte_r;
    bar_nxt = bar_r;
    los_nxt = los_r;
    if (q_pop) begin
      cmd_nxt = q_dout;
      cmd_v_nxt = 1'b1;
      // short delta fits one vlq byte, skip the high byte
      if ((q_dout.kind == dgm_pkg::CMD_NOTE_ON || q_dout.kind == dgm_pkg::CMD_NOTE_OFF) &&
          q_dout.delta <= dgm_pkg::VLQ_ONE_BYTE_MAX) begin
        idx_nxt = dgm_pkg::NOTE_IDX_DELTA_LO;
      end else begin
        idx_nxt = '0;
      end
    end
    if (emit) begin
      out_v_nxt = 1'b1;
      byte_nxt = cur_byte;
      bar_nxt = cur_final && (cmd_r.kind == dgm_pkg::CMD_EOT);
      los_nxt = cur_final && cmd_r.last;
      idx_nxt = idx_r + 3'd1;
      if (cur_final) begin
        cmd_v_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cmd_v_r <= cmd_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    byte_r <= byte_nxt;
    bar_r <= bar_nxt;
    los_r <= los_nxt;
  end

endmodule

@@ design/drum_grid_midi_track_encoder.sv @@
// top level of the four-voice drum grid to midi track byte encoder
// Each input beat is one half-step slot of the bar; it yields zero to 23 track
// bytes (tempo meta at bar start, delta-coded note-on or note-off per voice that
// hits the slot's step, end-of-track on the last slot), one byte per output beat,
// with last_of_slot on the slot's final byte and bar_done on the end-of-track's
// final byte. For each voice the front end runs a serial hit search of at most
// that voice's hit count; the serializer fetches a command only once the last
// one is done, and a four-entry command queue lets both run apart, so a slot is
// paced by the slower of the two; the front end stalls while the queue is full.
// In_ready is high only while the front end waits for a slot. Config writes are
// taken every cycle.
module drum_grid_midi_track_encoder #(
  parameter int NUM_STEPS = dgm_pkg::DEF_NUM_STEPS,
  parameter int TICKS_PER_QUARTER = dgm_pkg::DEF_TICKS_PER_QUARTER
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dgm_pkg::GENE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_restart_bar,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_track_byte,
  output logic                          out_bar_done,
  output logic                          out_last_of_slot
);

  dgm_pkg::cmd_t q_din, q_dout;
  dgm_pkg::q_stat_t q_stat;
  logic q_push, q_pop;

  // slot front end
  dgm_front #(
    .NUM_STEPS(NUM_STEPS),
    .TICKS_PER_QUARTER(TICKS_PER_QUARTER)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_restart_bar(in_restart_bar),
    .q_stat(q_stat),
    .q_push(q_push),
    .q_din(q_din)
  );

  // command queue
  dgm_queue #(
    .DEPTH(dgm_pkg::Q_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .din(q_din),
    .pop(q_pop),
    .dout(q_dout),
    .stat(q_stat)
  );

  // byte serializer
  dgm_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_dout(q_dout),
    .q_stat(q_stat),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_track_byte(out_track_byte),
    .out_bar_done(out_bar_done),
    .out_last_of_slot(out_last_of_slot)
  );

endmodule
